### src/bdpt_pkg.sv
// Shared types and codes for the button debouncer with press timer.
// No dependencies; every other file in src refers to this package by scoped name.
package bdpt_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int DUR_WIDTH  = 32;
  localparam int DLY_WIDTH  = 16;
  localparam int ADDR_WIDTH = 3;

  // Phase codes
  localparam logic [1:0] PH_OFF   = 2'd0;
  localparam logic [1:0] PH_OFFON = 2'd1;
  localparam logic [1:0] PH_ON    = 2'd2;
  localparam logic [1:0] PH_ONOFF = 2'd3;

  // Event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  // Register indexes
  localparam logic REG_ACTIVE_LEVEL = 1'b0;
  localparam logic REG_DEBOUNCE_MS  = 1'b1;

  localparam logic [DLY_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;

  typedef struct packed {
    logic                 active_level;
    logic [DLY_WIDTH-1:0] debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           event_res;
    logic [DUR_WIDTH-1:0] press_duration;
  } res_t;

  typedef struct packed {
    logic [1:0]            phase;
    logic [TIME_WIDTH-1:0] time_now;
  } stat_t;

endpackage

### src/button_debouncer_press_timer_unit.sv
// Top level of the button debouncer with press timer.
// Depends on bdpt_pkg, bdpt_regs, bdpt_core and bdpt_out_buf.
//
// Usage:
//   Input channel (in_valid/in_ready, pin_level): one item per millisecond
//   tick carrying the sampled pin level. Output channel (out_valid/out_ready,
//   event_res, press_duration): exactly one result item per input item;
//   event_res is none, press confirmed or release confirmed, and
//   press_duration holds the press length in ticks with a release event.
//   APB port: register 0 (address 0) active level, register 1 (address 4)
//   debounce delay in ticks. Write only while the block is idle.
// Timing:
//   Results go to the result register, or to the skid stage while the output
//   stalls. Throughput is one item per cycle unless the output stalls, set by
//   the phase update feeding the result register. The two-deep output lets one
//   more item in while a result waits; in_ready drops once both are full.
// Reset (rst, synchronous): phase off, counters and press start cleared,
//   active level 1, debounce delay 50, output empty.
module button_debouncer_press_timer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            pin_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      event_res,
  output logic [bdpt_pkg::DUR_WIDTH-1:0]  press_duration,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bdpt_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  bdpt_pkg::cfg_t  cfg;
  bdpt_pkg::res_t  res;
  bdpt_pkg::res_t  out_res;
  bdpt_pkg::stat_t stat;
  logic            in_fire;

  assign in_fire = in_valid & in_ready;

  bdpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdpt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .pin_level (pin_level),
    .res       (res),
    .stat      (stat)
  );

  bdpt_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign event_res      = out_res.event_res;
  assign press_duration = out_res.press_duration;

`ifndef ASSERT_OFF
  a_release_from_onoff: assert property (@(posedge clk) disable iff (rst)
    in_fire && res.event_res == bdpt_pkg::EV_RELEASE |-> stat.phase == bdpt_pkg::PH_ONOFF)
    else $error("release event outside on-to-off phase");

  a_press_enters_on: assert property (@(posedge clk) disable iff (rst)
    in_fire && res.event_res == bdpt_pkg::EV_PRESS |=> stat.phase == bdpt_pkg::PH_ON)
    else $error("press event did not enter on phase");

  a_time_advances: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> stat.time_now == bdpt_pkg::TIME_WIDTH'($past(stat.time_now) + 1'b1))
    else $error("millisecond counter did not advance on accepted item");

  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("skid stage holds an item while the result register is empty");
`endif

endmodule

### src/bdpt_regs.sv
// APB configuration registers: active level and debounce delay.
// Depends on bdpt_pkg.
module bdpt_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bdpt_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output bdpt_pkg::cfg_t                     cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level <= 1'b1;
      cfg.debounce_ms  <= bdpt_pkg::DEBOUNCE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        bdpt_pkg::REG_ACTIVE_LEVEL: cfg.active_level <= pwdata[0];
        bdpt_pkg::REG_DEBOUNCE_MS:  cfg.debounce_ms  <= pwdata[bdpt_pkg::DLY_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bdpt_pkg::REG_ACTIVE_LEVEL: prdata = {31'd0, cfg.active_level};
      bdpt_pkg::REG_DEBOUNCE_MS:  prdata = {16'd0, cfg.debounce_ms};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

### src/bdpt_core.sv
// Debounce phase tracker, millisecond counter and press timer.
// Result is formed from the current state and the tick's pin level. Depends on bdpt_pkg.
module bdpt_core (
  input  logic            clk,
  input  logic            rst,
  input  bdpt_pkg::cfg_t  cfg,
  input  logic            in_fire,
  input  logic            pin_level,
  output bdpt_pkg::res_t  res,
  output bdpt_pkg::stat_t stat
);

  logic [1:0]                          phase;
  logic [1:0]                          phase_next;
  logic [bdpt_pkg::DLY_WIDTH-1:0]      delay_count;
  logic [bdpt_pkg::DLY_WIDTH-1:0]      delay_count_next;
  logic [bdpt_pkg::DLY_WIDTH-1:0]      cnt_inc;
  logic [bdpt_pkg::TIME_WIDTH-1:0]     time_now;
  logic [bdpt_pkg::TIME_WIDTH-1:0]     press_start;
  logic                                start_press;
  logic [bdpt_pkg::TIME_WIDTH-1:0]     dur_full;
  logic [63:0]                         dur_ext;
  logic                                on;

  assign on       = cfg.active_level;
  assign cnt_inc  = (delay_count != '1) ? delay_count + 1'b1 : delay_count;
  assign dur_full = time_now - press_start;
  assign dur_ext  = 64'(dur_full);

  always_comb begin
    phase_next         = phase;
    delay_count_next   = delay_count;
    start_press        = 1'b0;
    res.event_res      = bdpt_pkg::EV_NONE;
    res.press_duration = '0;
    case (phase)
      bdpt_pkg::PH_OFF: begin
        if (pin_level == on) begin
          phase_next       = bdpt_pkg::PH_OFFON;
          delay_count_next = '0;
          start_press      = 1'b1;
        end
      end
      bdpt_pkg::PH_ON: begin
        if (pin_level != on) begin
          phase_next       = bdpt_pkg::PH_ONOFF;
          delay_count_next = '0;
        end
      end
      bdpt_pkg::PH_OFFON: begin
        delay_count_next = cnt_inc;
        if (cnt_inc >= cfg.debounce_ms) begin
          delay_count_next = '0;
          if (pin_level == on) begin
            phase_next    = bdpt_pkg::PH_ON;
            res.event_res = bdpt_pkg::EV_PRESS;
          end else begin
            phase_next = bdpt_pkg::PH_OFF;
          end
        end
      end
      default: begin
        delay_count_next = cnt_inc;
        if (cnt_inc >= cfg.debounce_ms) begin
          delay_count_next = '0;
          if (pin_level != on) begin
            phase_next         = bdpt_pkg::PH_OFF;
            res.event_res      = bdpt_pkg::EV_RELEASE;
            res.press_duration = dur_ext[bdpt_pkg::DUR_WIDTH-1:0];
          end else begin
            phase_next = bdpt_pkg::PH_ON;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= bdpt_pkg::PH_OFF;
      delay_count <= '0;
      time_now    <= '0;
      press_start <= '0;
    end else if (in_fire) begin
      phase       <= phase_next;
      delay_count <= delay_count_next;
      time_now    <= time_now + 1'b1;
      if (start_press) begin
        press_start <= time_now;
      end
    end
  end

  assign stat.phase    = phase;
  assign stat.time_now = time_now;

endmodule

### src/bdpt_out_buf.sv
// Result register with a skid stage so a new item is taken while a result waits.
// Depends on bdpt_pkg.
module bdpt_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  bdpt_pkg::res_t res,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output bdpt_pkg::res_t out_res
);

  logic           skid_valid;
  bdpt_pkg::res_t skid_res;
  logic           out_free;

  assign in_ready = ~skid_valid;
  assign out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      // output stalled: park the item
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (!out_free && in_fire) begin
      skid_res <= res;
    end
  end

endmodule

### bench/bdpt_event_checker.sv
// Event checker for the button debouncer with press timer: predicts every result item
// from the accepted ticks and the APB writes, and compares the output channel in order.
// Depends on bdpt_pkg for widths, phase, event and register codes.
module bdpt_event_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            pin_level,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [1:0]                      event_res,
  input  logic [bdpt_pkg::DUR_WIDTH-1:0]  press_duration,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [bdpt_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output int                              outstanding,
  output int                              mismatches
);
  import bdpt_pkg::*;

  cfg_t                  cfg;
  logic [1:0]            ph;
  logic [DLY_WIDTH-1:0]  dly_cnt;
  logic [TIME_WIDTH-1:0] ms_now;
  logic [TIME_WIDTH-1:0] press_t0;
  res_t                  due_events[$];

  always @(posedge clk) begin : track
    res_t                  nxt;
    res_t                  want;
    logic                  lvl;
    logic [TIME_WIDTH-1:0] held;
    if (rst) begin
      cfg.active_level = 1'b1;
      cfg.debounce_ms  = DEBOUNCE_RESET;
      ph               = PH_OFF;
      dly_cnt          = '0;
      ms_now           = '0;
      press_t0         = '0;
      mismatches       = 0;
      due_events.delete();
    end else begin
      // Results leave before the tick of this edge is predicted.
      if (out_valid && out_ready) begin
        if (due_events.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result item: ev=%0d dur=%0d", event_res, press_duration);
        end else begin
          want = due_events.pop_front();
          if (event_res !== want.event_res || press_duration !== want.press_duration) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("result mismatch: want ev=%0d dur=%0d, got ev=%0d dur=%0d",
                       want.event_res, want.press_duration, event_res, press_duration);
          end
        end
      end

      if (in_valid && in_ready) begin
        lvl = pin_level;
        nxt.event_res      = EV_NONE;
        nxt.press_duration = '0;
        if (ph == PH_OFF || ph == PH_ON) begin
          if (lvl == ((ph == PH_OFF) ? cfg.active_level : ~cfg.active_level)) begin
            if (ph == PH_OFF)
              press_t0 = ms_now;
            ph      = (ph == PH_OFF) ? PH_OFFON : PH_ONOFF;
            dly_cnt = '0;
          end
        end else begin
          // Saturate the bounce count; a zero delay then confirms on the next tick.
          if (dly_cnt != '1)
            dly_cnt = dly_cnt + 1'b1;
          if (dly_cnt >= cfg.debounce_ms) begin
            dly_cnt = '0;
            if (ph == PH_OFFON) begin
              if (lvl == cfg.active_level) begin
                ph            = PH_ON;
                nxt.event_res = EV_PRESS;
              end else begin
                ph = PH_OFF;
              end
            end else if (lvl != cfg.active_level) begin
              ph                 = PH_OFF;
              held               = ms_now - press_t0;
              nxt.event_res      = EV_RELEASE;
              nxt.press_duration = held[DUR_WIDTH-1:0];
            end else begin
              ph = PH_ON;
            end
          end
        end
        ms_now = ms_now + 1'b1;
        due_events.push_back(nxt);
      end

      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_DEBOUNCE_MS)
          cfg.debounce_ms = pwdata[DLY_WIDTH-1:0];
        else
          cfg.active_level = pwdata[0];
      end
    end
    outstanding <= due_events.size();
  end

endmodule

### bench/button_debouncer_press_timer_unit_test.sv
// Testbench top for button_debouncer_press_timer_unit: drives ticks and APB writes
// under several idling patterns and gives the verdict from bdpt_event_checker.
// Depends on bdpt_pkg, the block under src and bench/bdpt_event_checker.sv.
module button_debouncer_press_timer_unit_test;
  import bdpt_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  localparam int QUIET_LIMIT = 3000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  pin_level = 1'b1;
  logic                  out_ready = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr     = '0;
  logic [31:0]           pwdata    = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic [1:0]            event_res;
  logic [DUR_WIDTH-1:0]  press_duration;
  logic [31:0]           prdata;
  logic                  pready;
  int                    outstanding;
  int                    mismatches;
  int                    in_gap_pct = 0;
  int                    stall_pct  = 0;
  int                    quiet      = 0;

  always #6 clk = ~clk;

  button_debouncer_press_timer_unit DUT (
    .clk, .rst, .in_valid, .in_ready, .pin_level, .out_valid, .out_ready,
    .event_res, .press_duration, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  bdpt_event_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .pin_level, .out_valid, .out_ready,
    .event_res, .press_duration, .psel, .penable, .pwrite, .pready, .paddr,
    .pwdata, .outstanding, .mismatches
  );

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= stall_pct);

  // Abort when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin in_gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin in_gap_pct = 83; stall_pct = 0;  end
      IDLE_RECEIVER: begin in_gap_pct = 0;  stall_pct = 83; end
      default:       begin in_gap_pct = 33; stall_pct = 33; end
    endcase
  endtask

  // Call at a falling edge; returns at the falling edge after the item is taken.
  task automatic push_tick(input logic lvl);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    pin_level <= lvl;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold off the sender until every result item is back.
  task automatic drain;
    in_valid <= 1'b0;
    while (outstanding != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic act, input logic [DLY_WIDTH-1:0] dly);
    drain();
    reg_write(REG_ACTIVE_LEVEL, {31'($urandom_range(32'h7fff_ffff)), act});
    reg_write(REG_DEBOUNCE_MS, {16'($urandom_range(16'hffff)), dly});
  endtask

  // Send the n low bits of pat, oldest tick in the highest bit.
  task automatic send_pattern(input logic [31:0] pat, input int n);
    for (int k = n - 1; k >= 0; k--)
      push_tick(pat[k]);
  endtask

  // Level runs mostly long enough to confirm, with short runs and single-tick glitches.
  task automatic random_ticks(input int n, input logic act, input int dly);
    int   run_left;
    logic hold;
    logic lvl;
    run_left = $urandom_range(3);
    hold     = ~act;
    for (int k = 0; k < n; k++) begin
      if (run_left == 0) begin
        hold = ~hold;
        if ($urandom_range(3) != 0)
          run_left = dly + 1 + $urandom_range(5);
        else
          run_left = 1 + $urandom_range(dly);
      end
      run_left--;
      lvl = hold;
      if ($urandom_range(9) == 0)
        lvl = ~lvl;
      push_tick(lvl);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_idling(IDLE_NONE);

    // Lower the delay in the middle of a bounce: confirm on the next tick.
    configure(1'b1, 16'd10);
    send_pattern(32'b1011, 4);
    configure(1'b1, 16'd2);
    push_tick(1'b1);

    // Press, release, failed press and failed release at a short delay.
    configure(1'b1, 16'd3);
    send_pattern(32'b01011_0110_1000_1111_0111, 21);

    // Zero delay acts like one, active low.
    configure(1'b0, 16'd0);
    send_pattern(32'b0010_1101, 8);

    for (int p = 0; p < 8; p++) begin
      int dly;
      case (p)
        0:       dly = 1;
        1:       dly = 4;
        2:       dly = 2;
        3:       dly = 8;
        default: dly = $urandom_range(1, 12);
      endcase
      set_idling(idle_mode_e'(p % 4));
      configure((p < 4) ? 1'b1 : 1'b0, dly[DLY_WIDTH-1:0]);
      random_ticks(130, (p < 4) ? 1'b1 : 1'b0, dly);
    end

    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
src/bdpt_pkg.sv
src/bdpt_regs.sv
src/bdpt_core.sv
src/bdpt_out_buf.sv
src/button_debouncer_press_timer_unit.sv
bench/bdpt_event_checker.sv
bench/button_debouncer_press_timer_unit_test.sv
